/* hw/rtl/efg_pkg.sv */
// Package for the event flag group: sizes, codes, waiter entry and cell control types.
// Shared by the cell module and the top level; depends on nothing else.
package efg_pkg;

    localparam int FLAG_BITS   = 16;
    localparam int MAX_WAITERS = 8;
    localparam int MAX_TASKS   = 16;

    localparam int FLAG_W = 16;
    localparam int TASK_W = 4;
    localparam int CNT_W  = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

    localparam logic [FLAG_W-1:0] FLAG_KEEP =
        (FLAG_BITS >= FLAG_W) ? {FLAG_W{1'b1}} : FLAG_W'((64'd1 << FLAG_BITS) - 64'd1);

    localparam logic [1:0] CMD_PEND  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    typedef enum logic [2:0] {
        KIND_SATISFIED = 3'd0,
        KIND_BLOCKED   = 3'd1,
        KIND_WOKEN     = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_FULL      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [FLAG_W-1:0] mask;
        logic              wait_all;
    } waiter_t;

    typedef struct packed {
        logic             shift;
        logic             wr_en;
        logic [IDX_W-1:0] wr_pos;
        waiter_t          wdata;
    } cell_ctl_t;

    function automatic logic cond_holds(logic [FLAG_W-1:0] flags,
                                        logic [FLAG_W-1:0] mask,
                                        logic              all);
        logic hit;
        if (all)
        begin
            hit = ((flags & mask) == mask);
        end
        else
        begin
            hit = ((flags & mask) != '0);
        end
        return hit;
    endfunction

    // Folds a task identifier into the range of task numbers. The task count is a
    // power of two, so this reduces to keeping the low bits.
    function automatic logic [TASK_W-1:0] task_wrap(logic [TASK_W-1:0] t);
        return TASK_W'(int'(t) % MAX_TASKS);
    endfunction

endpackage

/* hw/rtl/efg_if.sv */
// Handshake interfaces for the command and result channels of the event flag group.
// Field widths follow the fixed item layout; depends on nothing else.
interface efg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  task_id;
    logic [15:0] flag_mask;
    logic        wait_all;

    modport source (output valid, cmd, task_id, flag_mask, wait_all, input ready);
    modport sink (input valid, cmd, task_id, flag_mask, wait_all, output ready);
endinterface

interface efg_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  woken_task;
    logic [15:0] flags_now;
    logic        last;

    modport source (output valid, kind, woken_task, flags_now, last, input ready);
    modport sink (input valid, kind, woken_task, flags_now, last, output ready);
endinterface

/* hw/rtl/efg_cell.sv */
// One waiter slot of the event flag group chain.
// Uses efg_pkg for the entry and control types.
module efg_cell (
    input  logic                        clk,
    input  efg_pkg::cell_ctl_t          ctl,
    input  logic [efg_pkg::IDX_W-1:0]   my_idx,
    input  efg_pkg::waiter_t            right,
    output efg_pkg::waiter_t            entry
);

    efg_pkg::waiter_t entry_reg;

    // A write aimed at this slot wins over the shift from the right-hand neighbor.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (ctl.wr_pos == my_idx))
        begin
            entry_reg <= ctl.wdata;
        end
        else if (ctl.shift)
        begin
            entry_reg <= right;
        end
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/event_flag_group_core.sv */
// Event flag group: a pend gives one result (satisfied, blocked or full); a set walks
// each waiter through the cell chain, one result per woken waiter, then a done result;
// reset flags and unused commands give a done result. One item is in work at a time. A
// result register lets the next item be taken while the last result waits. Reset gives
// flag word 0 and an empty list, no clearing pass.
module event_flag_group_core (
    input  logic                        clk,
    input  logic                        rst_n,
    efg_cmd_if.sink                     req,
    efg_rsp_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic [efg_pkg::FLAG_W-1:0]  cfg_wdata
);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     cmd_reg, cmd_next;
    logic [efg_pkg::TASK_W-1:0]     task_reg, task_next;
    logic [efg_pkg::FLAG_W-1:0]     mask_reg, mask_next;
    logic                           all_reg, all_next;
    logic [efg_pkg::FLAG_W-1:0]     flag_reg, flag_next;
    logic [efg_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [efg_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [efg_pkg::CNT_W-1:0]      keep_reg, keep_next;
    logic                           out_valid_reg, out_valid_next;
    efg_pkg::kind_t                 kind_reg, kind_next;
    logic [efg_pkg::TASK_W-1:0]     otask_reg, otask_next;
    logic [efg_pkg::FLAG_W-1:0]     oflags_reg, oflags_next;
    logic                           last_reg, last_next;

    efg_pkg::cell_ctl_t             ctl;
    efg_pkg::waiter_t               cell_q [efg_pkg::MAX_WAITERS];
    efg_pkg::waiter_t               head;
    logic                           slot_free;
    logic                           accept;
    logic [efg_pkg::FLAG_W-1:0]     in_mask;

    genvar gi;
    generate
        for (gi = 0; gi < efg_pkg::MAX_WAITERS; gi++)
        begin : g_cell
            efg_pkg::waiter_t right;
            if (gi == efg_pkg::MAX_WAITERS - 1)
            begin : g_tail
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = cell_q[gi + 1];
            end
            efg_cell u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .my_idx (efg_pkg::IDX_W'(gi)),
                .right  (right),
                .entry  (cell_q[gi])
            );
        end
    endgenerate

    assign head      = cell_q[0];
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign in_mask   = req.flag_mask & efg_pkg::FLAG_KEEP;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        task_next      = task_reg;
        mask_next      = mask_reg;
        all_next       = all_reg;
        flag_next      = flag_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        otask_next     = otask_reg;
        oflags_next    = oflags_reg;
        last_next      = last_reg;

        ctl.shift         = 1'b0;
        ctl.wr_en         = 1'b0;
        ctl.wr_pos        = '0;
        ctl.wdata.task_id = task_reg;
        ctl.wdata.mask    = mask_reg;
        ctl.wdata.wait_all = all_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    task_next  = efg_pkg::task_wrap(req.task_id);
                    mask_next  = in_mask;
                    all_next   = req.wait_all;
                    rem_next   = count_reg;
                    keep_next  = '0;
                    state_next = S_RUN;
                    if (req.cmd == efg_pkg::CMD_SET)
                    begin
                        flag_next = (flag_reg | in_mask) & efg_pkg::FLAG_KEEP;
                    end
                    else if (req.cmd == efg_pkg::CMD_RESET)
                    begin
                        flag_next = flag_reg & ~in_mask;
                    end
                end
            end
            S_RUN:
            begin
                case (cmd_reg)
                    efg_pkg::CMD_PEND:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            otask_next     = task_reg;
                            oflags_next    = flag_reg;
                            last_next      = 1'b1;
                            state_next     = S_IDLE;
                            if (efg_pkg::cond_holds(flag_reg, mask_reg, all_reg))
                            begin
                                kind_next = efg_pkg::KIND_SATISFIED;
                            end
                            else if (count_reg < efg_pkg::CNT_W'(efg_pkg::MAX_WAITERS))
                            begin
                                kind_next  = efg_pkg::KIND_BLOCKED;
                                ctl.wr_en  = 1'b1;
                                ctl.wr_pos = count_reg[efg_pkg::IDX_W-1:0];
                                count_next = count_reg + efg_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                kind_next = efg_pkg::KIND_FULL;
                            end
                        end
                    end
                    efg_pkg::CMD_SET:
                    begin
                        if (rem_reg != '0)
                        begin
                            // The head leaves each step, but a woken head waits for a free result slot; a kept waiter
                            // is written back just behind the waiters already kept.
                            if (efg_pkg::cond_holds(flag_reg, head.mask, head.wait_all))
                            begin
                                if (slot_free)
                                begin
                                    out_valid_next = 1'b1;
                                    kind_next      = efg_pkg::KIND_WOKEN;
                                    otask_next     = head.task_id;
                                    oflags_next    = flag_reg;
                                    last_next      = 1'b0;
                                    ctl.shift      = 1'b1;
                                    rem_next       = rem_reg - efg_pkg::CNT_W'(1);
                                end
                            end
                            else
                            begin
                                ctl.shift  = 1'b1;
                                ctl.wr_en  = 1'b1;
                                ctl.wr_pos = efg_pkg::IDX_W'(rem_reg + keep_reg
                                                             - efg_pkg::CNT_W'(1));
                                ctl.wdata  = head;
                                rem_next   = rem_reg - efg_pkg::CNT_W'(1);
                                keep_next  = keep_reg + efg_pkg::CNT_W'(1);
                            end
                        end
                        else if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = efg_pkg::KIND_DONE;
                            otask_next     = '0;
                            oflags_next    = flag_reg;
                            last_next      = 1'b1;
                            count_next     = keep_reg;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = efg_pkg::KIND_DONE;
                            otask_next     = '0;
                            oflags_next    = flag_reg;
                            last_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Writing the register re-creates the group.
        if (cfg_we)
        begin
            flag_next  = cfg_wdata & efg_pkg::FLAG_KEEP;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= efg_pkg::CMD_PEND;
            task_reg      <= '0;
            mask_reg      <= '0;
            all_reg       <= 1'b0;
            flag_reg      <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= efg_pkg::KIND_DONE;
            otask_reg     <= '0;
            oflags_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            task_reg      <= task_next;
            mask_reg      <= mask_next;
            all_reg       <= all_next;
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            otask_reg     <= otask_next;
            oflags_reg    <= oflags_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = kind_reg;
    assign rsp.woken_task = otask_reg;
    assign rsp.flags_now  = oflags_reg;
    assign rsp.last       = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= efg_pkg::CNT_W'(efg_pkg::MAX_WAITERS))
        else $error("waiter count exceeds the list size");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we |=> state_reg == S_RUN)
        else $error("accepted item did not start work");

    a_walk_only_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && (cmd_reg == efg_pkg::CMD_SET)
            |-> (rem_reg + keep_reg) <= count_reg)
        else $error("set walk lost track of the waiter list");

endmodule
